### rtl/mdce_pkg.sv
// ----------------------------------------------------------------------------
// mdce_pkg: shared types and constants of the diatonic chord expander
// message codes, scale tables, chord descriptor and config group
// ----------------------------------------------------------------------------
package mdce_pkg;

    localparam int NUM_TONES  = 9;
    localparam int TONE_IDX_W = $clog2(NUM_TONES);
    localparam int GAIN_W     = 9;
    localparam int NOTE_W     = 9;
    localparam int OFS_W      = 6;
    localparam int SEMITONES  = 12;

    // note / 12 as (note * 43) >> 9, exact for 7-bit notes
    localparam int DIV12_MUL   = 43;
    localparam int DIV12_SHIFT = 9;

    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CONTROL  = 4'hB;

    localparam logic [GAIN_W-1:0] GAIN_MIN  = 9'd3;
    localparam logic [GAIN_W-1:0] GAIN_FULL = 9'd256;

    localparam logic [2:0] DEG_BLACK = 3'd7;

    // bit i set when semitone i lies in the scale
    localparam logic [SEMITONES-1:0] IONIAN_MASK  = 12'b1010_1011_0101;
    localparam logic [SEMITONES-1:0] AEOLIAN_MASK = 12'b0101_1010_1101;

    localparam logic [OFS_W-1:0] OFS_UNISON    = OFS_W'(0);
    localparam logic [OFS_W-1:0] OFS_OCTAVE    = OFS_W'(12);
    localparam logic [OFS_W-1:0] OFS_OCT_BELOW = OFS_W'(-12);

    // chord tone order
    localparam int TONE_FIRST      = 0;
    localparam int TONE_BASS       = 1;
    localparam int TONE_THIRD      = 2;
    localparam int TONE_FIFTH      = 3;
    localparam int TONE_SEVENTH    = 4;
    localparam int TONE_OCTAVE     = 5;
    localparam int TONE_NINTH      = 6;
    localparam int TONE_ELEVENTH   = 7;
    localparam int TONE_THIRTEENTH = 8;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_SCALE_ROOT = 2'd0;
    localparam cfg_index_t CFG_MAJOR_MODE = 2'd1;
    localparam cfg_index_t CFG_GAINS_LOW  = 2'd2;
    localparam cfg_index_t CFG_GAINS_HIGH = 2'd3;

    localparam int CFG_DATA_W  = 45;
    localparam int GAINS_LOW_W = 36;

    typedef enum logic [1:0] {
        QUAL_MAJOR,
        QUAL_MINOR,
        QUAL_DIM
    } quality_t;

    typedef logic [TONE_IDX_W-1:0] tone_idx_t;

    typedef struct packed {
        logic [3:0]                          scale_root;
        logic                                major_mode;
        logic [NUM_TONES-1:0][GAIN_W-1:0]    gains;
    } cfg_t;

    typedef struct packed {
        logic                                is_chord;
        logic [7:0]                          status;
        logic [6:0]                          d1;
        logic [6:0]                          d2;
        logic signed [NOTE_W-1:0]            base;
        logic [NUM_TONES-1:0][OFS_W-1:0]     ofs;
    } chord_desc_t;

    function automatic logic [2:0] degree_of(input logic [3:0] note_class);
        logic [2:0] d;
        unique case (note_class)
            4'd0:    d = 3'd0;
            4'd2:    d = 3'd1;
            4'd4:    d = 3'd2;
            4'd5:    d = 3'd3;
            4'd7:    d = 3'd4;
            4'd9:    d = 3'd5;
            4'd11:   d = 3'd6;
            default: d = DEG_BLACK;
        endcase
        return d;
    endfunction

    function automatic logic [3:0] degree_offset(input logic maj, input logic [2:0] deg);
        logic [3:0] o;
        unique case (deg)
            3'd0:    o = 4'd0;
            3'd1:    o = 4'd2;
            3'd2:    o = maj ? 4'd4 : 4'd3;
            3'd3:    o = 4'd5;
            3'd4:    o = 4'd7;
            3'd5:    o = maj ? 4'd9 : 4'd8;
            3'd6:    o = maj ? 4'd11 : 4'd10;
            default: o = 4'd0;
        endcase
        return o;
    endfunction

    function automatic quality_t chord_quality(input logic maj, input logic [2:0] deg);
        quality_t q;
        if (maj)
        begin
            if (deg == 3'd0 || deg == 3'd3 || deg == 3'd4)
                q = QUAL_MAJOR;
            else if (deg == 3'd6)
                q = QUAL_DIM;
            else
                q = QUAL_MINOR;
        end
        else
        begin
            if (deg == 3'd2 || deg == 3'd5 || deg == 3'd6)
                q = QUAL_MAJOR;
            else if (deg == 3'd1)
                q = QUAL_DIM;
            else
                q = QUAL_MINOR;
        end
        return q;
    endfunction

    function automatic logic [3:0] mod12(input logic [4:0] v);
        logic [4:0] r;
        if (v >= 5'd24)
            r = v - 5'd24;
        else if (v >= 5'd12)
            r = v - 5'd12;
        else
            r = v;
        return r[3:0];
    endfunction

    function automatic logic scale_has(input logic maj, input logic [3:0] idx);
        return maj ? IONIAN_MASK[idx] : AEOLIAN_MASK[idx];
    endfunction

    // first k >= start with a scale tone k semitones above the degree
    function automatic logic [4:0] scan_up(input logic maj, input logic [3:0] off,
                                           input logic [4:0] start);
        logic [4:0] k;
        logic [4:0] res;
        logic       found;
        res   = start;
        found = 1'b0;
        for (int j = 0; j < SEMITONES; j++)
        begin
            k = start + 5'(j);
            if (!found && scale_has(maj, mod12(5'(off) + k)))
            begin
                found = 1'b1;
                res   = k;
            end
        end
        return res;
    endfunction

endpackage

### rtl/mdce_front.sv
// ----------------------------------------------------------------------------
// mdce_front: message classifier
// sorts each message into drop, forward or chord and builds the descriptor
// ----------------------------------------------------------------------------
module mdce_front (
    input  logic                           start,
    input  logic                           busy,
    input  logic [7:0]                     status_byte,
    input  logic [6:0]                     first_data,
    input  logic [6:0]                     second_data,
    input  mdce_pkg::cfg_t                 cfg,
    input  logic [mdce_pkg::NUM_TONES-1:0] tone_en,
    output logic                           push,
    output mdce_pkg::chord_desc_t          desc
);
    import mdce_pkg::*;

    logic [3:0]  msg_type;
    logic        is_note;
    logic        keep;
    logic [12:0] div_prod;
    logic [3:0]  octave;
    logic [6:0]  octave_base;
    logic [3:0]  note_class;
    logic [2:0]  deg;
    logic [3:0]  off;
    quality_t    qual;
    logic [OFS_W-1:0] third;
    logic [OFS_W-1:0] fifth;
    logic [OFS_W-1:0] seventh;

    always_comb
    begin
        msg_type    = status_byte[7:4];
        is_note     = (msg_type == MSG_NOTE_OFF) || (msg_type == MSG_NOTE_ON);

        div_prod    = 13'(first_data) * 13'(DIV12_MUL);
        octave      = div_prod[DIV12_SHIFT +: 4];
        octave_base = 7'(octave) * 7'(SEMITONES);
        note_class  = 4'(first_data - octave_base);
        deg         = degree_of(note_class);
        off         = degree_offset(cfg.major_mode, deg);
        qual        = chord_quality(cfg.major_mode, deg);

        unique case (qual)
            QUAL_MAJOR:
            begin
                third   = OFS_W'(4);
                fifth   = OFS_W'(7);
                seventh = OFS_W'(11);
            end
            QUAL_DIM:
            begin
                third   = OFS_W'(3);
                fifth   = OFS_W'(6);
                seventh = OFS_W'(9);
            end
            default:
            begin
                third   = OFS_W'(3);
                fifth   = OFS_W'(7);
                seventh = OFS_W'(10);
            end
        endcase

        if (is_note)
            keep = !(msg_type == MSG_NOTE_ON && second_data == 7'd0)
                   && (deg != DEG_BLACK) && (|tone_en);
        else
            keep = (msg_type != MSG_CONTROL);

        push = start && !busy && keep;

        desc.is_chord = is_note;
        desc.status   = status_byte;
        desc.d1       = first_data;
        desc.d2       = second_data;
        desc.base     = NOTE_W'(octave_base) + NOTE_W'(cfg.scale_root) + NOTE_W'(off);
        desc.ofs[TONE_FIRST]      = OFS_UNISON;
        desc.ofs[TONE_BASS]       = OFS_OCT_BELOW;
        desc.ofs[TONE_THIRD]      = third;
        desc.ofs[TONE_FIFTH]      = fifth;
        desc.ofs[TONE_SEVENTH]    = seventh;
        desc.ofs[TONE_OCTAVE]     = OFS_OCTAVE;
        desc.ofs[TONE_NINTH]      = OFS_OCTAVE + OFS_W'(scan_up(cfg.major_mode, off, 5'd1));
        desc.ofs[TONE_ELEVENTH]   = OFS_OCTAVE + OFS_W'(scan_up(cfg.major_mode, off, 5'd5));
        desc.ofs[TONE_THIRTEENTH] = OFS_OCTAVE + OFS_W'(scan_up(cfg.major_mode, off, 5'd8));
    end

endmodule

### rtl/mdce_queue.sv
// ----------------------------------------------------------------------------
// mdce_queue: descriptor queue
// small first-in first-out store between classifier and note sequencer
// ----------------------------------------------------------------------------
module mdce_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mdce_pkg::chord_desc_t push_data,
    input  logic                  pop,
    output mdce_pkg::chord_desc_t pop_data,
    output logic                  empty,
    output logic                  full
);
    import mdce_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    chord_desc_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        empty    = (count_reg == '0);
        full     = (count_reg == CNT_W'(DEPTH));
        pop_data = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;

        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/mdce_back.sv
// ----------------------------------------------------------------------------
// mdce_back: note sequencer
// walks the enabled chord tones of one descriptor, one result per cycle
// ----------------------------------------------------------------------------
module mdce_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mdce_pkg::cfg_t                 cfg,
    input  logic [mdce_pkg::NUM_TONES-1:0] tone_en,
    input  logic                           q_empty,
    input  mdce_pkg::chord_desc_t          q_data,
    output logic                           q_pop,
    output logic                           strobe,
    output logic [7:0]                     status_out,
    output logic [7:0]                     first_out,
    output logic [6:0]                     second_out,
    output logic                           note_out_of_range,
    output logic                           last_in_run
);
    import mdce_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    tone_idx_t   step_reg;
    tone_idx_t   step_next;
    chord_desc_t desc_reg;

    logic        strobe_reg;
    logic        strobe_next;
    logic [7:0]  status_reg;
    logic [7:0]  status_next;
    logic [7:0]  first_reg;
    logic [7:0]  first_next;
    logic [6:0]  second_reg;
    logic [6:0]  second_next;
    logic        oor_reg;
    logic        oor_next;
    logic        last_reg;
    logic        last_next;

    tone_idx_t                first_idx;
    tone_idx_t                nxt_idx;
    logic                     nxt_found;
    logic                     first_found;
    logic                     done;
    logic [OFS_W-1:0]         ofs_sel;
    logic signed [NOTE_W-1:0] note;
    logic [GAIN_W-1:0]        gain_raw;
    logic [GAIN_W-1:0]        gain_sat;
    logic [15:0]              vel_prod;

    // tone search: first enabled tone, and next enabled tone after the current one
    always_comb
    begin
        first_found = 1'b0;
        first_idx   = '0;
        nxt_found   = 1'b0;
        nxt_idx     = '0;
        for (int i = 0; i < NUM_TONES; i++)
        begin
            if (!first_found && tone_en[i])
            begin
                first_found = 1'b1;
                first_idx   = TONE_IDX_W'(i);
            end
            if (!nxt_found && tone_en[i] && (TONE_IDX_W'(i) > step_reg))
            begin
                nxt_found = 1'b1;
                nxt_idx   = TONE_IDX_W'(i);
            end
        end
    end

    // current tone arithmetic
    always_comb
    begin
        ofs_sel  = desc_reg.ofs[step_reg];
        note     = desc_reg.base + {{(NOTE_W - OFS_W){ofs_sel[OFS_W-1]}}, ofs_sel};
        gain_raw = cfg.gains[step_reg];
        gain_sat = (gain_raw > GAIN_FULL) ? GAIN_FULL : gain_raw;
        vel_prod = 16'(desc_reg.d2) * 16'(gain_sat) + 16'd128;
    end

    // sequencing
    always_comb
    begin
        done  = !desc_reg.is_chord || !nxt_found;
        q_pop = !q_empty && (!valid_reg || done);

        if (q_pop)
            valid_next = 1'b1;
        else
            valid_next = valid_reg && !done;

        if (q_pop)
            step_next = first_idx;
        else if (valid_reg)
            step_next = nxt_idx;
        else
            step_next = step_reg;
    end

    // result register contents
    always_comb
    begin
        strobe_next = valid_reg;
        status_next = desc_reg.status;
        last_next   = done;
        if (desc_reg.is_chord)
        begin
            first_next  = note[7:0];
            second_next = vel_prod[14:8];
            oor_next    = (note < 0) || (note > NOTE_W'(127));
        end
        else
        begin
            first_next  = {1'b0, desc_reg.d1};
            second_next = desc_reg.d2;
            oor_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            step_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            step_reg   <= step_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            desc_reg <= q_data;
        status_reg <= status_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        oor_reg    <= oor_next;
        last_reg   <= last_next;
    end

    assign strobe            = strobe_reg;
    assign status_out        = status_reg;
    assign first_out         = first_reg;
    assign second_out        = second_reg;
    assign note_out_of_range = oor_reg;
    assign last_in_run       = last_reg;

endmodule

### rtl/midi_diatonic_chord_expander_core.sv
// ----------------------------------------------------------------------------
// midi_diatonic_chord_expander_core: diatonic chord expander for MIDI messages
// turns white-key note messages into chord notes, forwards or drops the rest
// ----------------------------------------------------------------------------
// usage
//   input: a message (status_byte, first_data, second_data) is taken at a clock
//   edge where start is high and busy is low. busy rises only when the
//   descriptor queue (QUEUE_DEPTH entries) is full.
//   output: each result is shown for exactly one cycle with strobe high;
//   last_in_run marks the final result of a message. the receiver cannot
//   stall, so results are never held back once produced.
//   config: cfg_write with cfg_index/cfg_data updates a register at once;
//   write only while no message is still in flight.
// pipeline and throughput
//   with the sequencer idle, the first result of a transaction passes the queue
//   write at its accept edge, then the sequencer load, then the output
//   register; behind queued messages it waits for their results.
//   a chord message gives one result per enabled tone (1 to 9), a forwarded
//   message a single result; the note sequencer emitting one note per cycle sets
//   the rate, and the next queued message follows without a gap.
//   dropped messages (controller, black key, note-on at zero velocity, all
//   gains below 3) never enter the queue and never occupy the sequencer.
// reset
//   rst_n low empties the queue, clears strobe, sets scale_root 0,
//   major mode, and all gains 0.
// ----------------------------------------------------------------------------
module midi_diatonic_chord_expander_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  logic [7:0]                         status_byte,
    input  logic [6:0]                         first_data,
    input  logic [6:0]                         second_data,
    // configuration write port
    input  logic                               cfg_write,
    input  mdce_pkg::cfg_index_t               cfg_index,
    input  logic [mdce_pkg::CFG_DATA_W-1:0]    cfg_data,
    // result channel
    output logic                               strobe,
    output logic [7:0]                         status_out,
    output logic [7:0]                         first_out,
    output logic [6:0]                         second_out,
    output logic                               note_out_of_range,
    output logic                               last_in_run
);
    import mdce_pkg::*;

    localparam int GAINS_HIGH_W = CFG_DATA_W;

    // configuration registers
    logic [3:0]              scale_root_reg;
    logic                    major_mode_reg;
    logic [GAINS_LOW_W-1:0]  gains_low_reg;
    logic [GAINS_HIGH_W-1:0] gains_high_reg;

    cfg_t                    cfg;
    logic [NUM_TONES-1:0]    tone_en;

    // front to queue to back
    logic                    push;
    chord_desc_t             push_desc;
    logic                    q_pop;
    chord_desc_t             q_data;
    logic                    q_empty;
    logic                    q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_root_reg <= 4'd0;
            major_mode_reg <= 1'b1;
            gains_low_reg  <= '0;
            gains_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SCALE_ROOT: scale_root_reg <= cfg_data[3:0];
                CFG_MAJOR_MODE: major_mode_reg <= cfg_data[0];
                CFG_GAINS_LOW:  gains_low_reg  <= cfg_data[GAINS_LOW_W-1:0];
                CFG_GAINS_HIGH: gains_high_reg <= cfg_data[GAINS_HIGH_W-1:0];
                default:        ;
            endcase
        end
    end

    // gains are packed lowest tone first, low register then high register
    always_comb
    begin
        cfg.scale_root = scale_root_reg;
        cfg.major_mode = major_mode_reg;
        cfg.gains      = {gains_high_reg, gains_low_reg};
        // a tone sounds only when its gain reaches the threshold
        for (int i = 0; i < NUM_TONES; i++)
            tone_en[i] = (cfg.gains[i] >= GAIN_MIN);
    end

    assign busy = q_full;

    mdce_front u_front (
        .start       (start),
        .busy        (busy),
        .status_byte (status_byte),
        .first_data  (first_data),
        .second_data (second_data),
        .cfg         (cfg),
        .tone_en     (tone_en),
        .push        (push),
        .desc        (push_desc)
    );

    mdce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    mdce_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .tone_en           (tone_en),
        .q_empty           (q_empty),
        .q_data            (q_data),
        .q_pop             (q_pop),
        .strobe            (strobe),
        .status_out        (status_out),
        .first_out         (first_out),
        .second_out        (second_out),
        .note_out_of_range (note_out_of_range),
        .last_in_run       (last_in_run)
    );

    // a chord run is emitted without gaps and keeps its status byte
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_in_run |=> strobe && (status_out == $past(status_out)))
        else $error("chord run broken before its last note");

    // wrapped notes are exactly those with bit 7 set
    a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (note_out_of_range == first_out[7]))
        else $error("out-of-range flag disagrees with note value");

    // forwarded messages are single, in-range transactions
    a_forward_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status_out[7:4] != MSG_NOTE_ON) && (status_out[7:4] != MSG_NOTE_OFF)
        |-> last_in_run && !note_out_of_range)
        else $error("forwarded message not a single result");

endmodule

### tb/midi_diatonic_chord_expander_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_diatonic_chord_expander_core_tb: self-checking bench for the chord expander
// feeds midi transactions through the command port, predicts every chord note,
// forwarded and dropped message, and checks each strobed result in order
// ----------------------------------------------------------------------------
module midi_diatonic_chord_expander_core_tb;

    import mdce_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_PAD    = 8;     // covers queue write, sequencer load, output reg
    localparam int END_PAD      = 12;
    localparam int STALL_LIMIT  = 1000;  // longest quiet stretch is a gap plus a config pause
    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 35;
    localparam int BLACK_KEY    = -1;

    // note class to scale degree, black keys marked
    localparam int KEY_DEGREE [SEMITONES] = '{0, BLACK_KEY, 1, BLACK_KEY, 2, 3,
                                              BLACK_KEY, 4, BLACK_KEY, 5, BLACK_KEY, 6};
    localparam int WHITE_CLASS [7] = '{0, 2, 4, 5, 7, 9, 11};

    localparam logic [35:0] FULL_LO = {4{GAIN_FULL}};
    localparam logic [44:0] FULL_HI = {5{GAIN_FULL}};

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
    } midi_msg_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] note;
        logic [6:0] vel;
        logic       oor;
        logic       last;
    } chord_note_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // block inputs, all known from time zero
    logic                  start       = 1'b0;
    logic [7:0]            status_byte = '0;
    logic [6:0]            first_data  = '0;
    logic [6:0]            second_data = '0;
    logic                  cfg_write   = 1'b0;
    cfg_index_t            cfg_index   = CFG_SCALE_ROOT;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // block outputs
    logic       busy;
    logic       strobe;
    logic [7:0] status_out;
    logic [7:0] first_out;
    logic [6:0] second_out;
    logic       note_out_of_range;
    logic       last_in_run;

    midi_diatonic_chord_expander_core DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .status_byte       (status_byte),
        .first_data        (first_data),
        .second_data       (second_data),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .strobe            (strobe),
        .status_out        (status_out),
        .first_out         (first_out),
        .second_out        (second_out),
        .note_out_of_range (note_out_of_range),
        .last_in_run       (last_in_run)
    );

    // shadow copy of the configuration registers
    logic [3:0]  key_root  = 4'd0;
    logic        major_sel = 1'b1;
    logic [35:0] gains_lo  = '0;
    logic [44:0] gains_hi  = '0;

    midi_msg_t   pending_msgs [$];   // transactions not yet offered to the block
    chord_note_t expected_notes [$]; // results still owed by the block
    int          msgs_sent    = 0;
    int          msgs_taken   = 0;
    int          mismatches   = 0;
    logic        sender_idles = 1'b1;
    int          gap_left     = 0;
    int          stall_cycles = 0;

    // first tone of the scale at least 'from' semitones above the degree
    function automatic int tone_above(input logic [11:0] scale, input int ofs, input int from);
        int j;
        for (j = 0; j < SEMITONES; j++)
        begin
            if (scale[(ofs + from + j) % SEMITONES])
                return from + j;
        end
        return from;
    endfunction

    // work out what one accepted message makes the block emit
    function automatic void predict_chord(input logic [7:0] st, input logic [6:0] d1,
                                          input logic [6:0] d2);
        logic [3:0]  kind;
        logic [11:0] scale;
        quality_t    qual;
        chord_note_t nt;
        chord_note_t run [$];
        int          deg;
        int          step_ofs;
        int          cnt;
        int          base;
        int          k;
        int          g;
        int          tone [NUM_TONES];
        kind = st[7:4];
        if (kind != MSG_NOTE_ON && kind != MSG_NOTE_OFF)
        begin
            // controllers vanish, anything else passes through untouched
            if (kind != MSG_CONTROL)
            begin
                nt = '{status: st, note: {1'b0, d1}, vel: d2, oor: 1'b0, last: 1'b1};
                expected_notes.push_back(nt);
            end
            return;
        end
        if (kind == MSG_NOTE_ON && d2 == 7'd0)
            return;
        deg = KEY_DEGREE[d1 % 12];
        if (deg == BLACK_KEY)
            return;

        scale = major_sel ? IONIAN_MASK : AEOLIAN_MASK;
        // semitone of the degree: the deg-th tone present in the scale
        cnt      = 0;
        step_ofs = 0;
        for (k = 0; k < SEMITONES; k++)
        begin
            if (scale[k])
            begin
                if (cnt == deg)
                    step_ofs = k;
                cnt++;
            end
        end

        if (major_sel)
            qual = (deg == 0 || deg == 3 || deg == 4) ? QUAL_MAJOR :
                   (deg == 6) ? QUAL_DIM : QUAL_MINOR;
        else
            qual = (deg == 2 || deg == 5 || deg == 6) ? QUAL_MAJOR :
                   (deg == 1) ? QUAL_DIM : QUAL_MINOR;

        base = (int'(d1) / 12) * 12 + int'(key_root) + step_ofs;
        tone[TONE_FIRST]      = base;
        tone[TONE_BASS]       = base - 12;
        tone[TONE_THIRD]      = base + ((qual == QUAL_MAJOR) ? 4 : 3);
        tone[TONE_FIFTH]      = base + ((qual == QUAL_DIM) ? 6 : 7);
        tone[TONE_SEVENTH]    = base + ((qual == QUAL_DIM) ? 9 :
                                        (qual == QUAL_MAJOR) ? 11 : 10);
        tone[TONE_OCTAVE]     = base + 12;
        tone[TONE_NINTH]      = base + 12 + tone_above(scale, step_ofs, 1);
        tone[TONE_ELEVENTH]   = base + 12 + tone_above(scale, step_ofs, 5);
        tone[TONE_THIRTEENTH] = base + 12 + tone_above(scale, step_ofs, 8);

        for (k = 0; k < NUM_TONES; k++)
        begin
            g = (k < 4) ? int'(gains_lo[9*k +: 9]) : int'(gains_hi[9*(k-4) +: 9]);
            if (g > int'(GAIN_FULL))
                g = int'(GAIN_FULL);
            if (g < int'(GAIN_MIN))
                continue;
            nt.status = st;
            nt.note   = 8'(tone[k]);
            nt.vel    = 7'((int'(d2) * g + 128) >> 8);
            nt.oor    = (tone[k] < 0 || tone[k] > 127);
            nt.last   = 1'b0;
            run.push_back(nt);
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            expected_notes.push_back(run[i]);
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers queued messages, with sender_idles each followed by its own idle gap
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        midi_msg_t nxt;
        if (!rst_n)
        begin
            start       <= 1'b0;
            status_byte <= '0;
            first_data  <= '0;
            second_data <= '0;
            gap_left    <= 0;
        end
        else
        begin
            // transaction accepted on this edge
            if (start && !busy)
            begin
                predict_chord(status_byte, first_data, second_data);
                msgs_taken++;
            end
            // while busy the offer stays up unchanged
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (pending_msgs.size() > 0)
                begin
                    nxt = pending_msgs.pop_front();
                    status_byte <= nxt.status;
                    first_data  <= nxt.d1;
                    second_data <= nxt.d2;
                    start       <= 1'b1;
                    gap_left    <= sender_idles ? int'($urandom_range(0, MAX_GAP)) : 0;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every strobed result must match the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        chord_note_t want;
        if (rst_n && strobe)
        begin
            if (expected_notes.size() == 0)
            begin
                $error("unexpected result: status_out %0h first_out %0d second_out %0d",
                       status_out, first_out, second_out);
                mismatches++;
            end
            else
            begin
                want = expected_notes.pop_front();
                if (status_out !== want.status)
                begin
                    $error("status_out: expected %0h, actual %0h", want.status, status_out);
                    mismatches++;
                end
                if (first_out !== want.note)
                begin
                    $error("first_out: expected %0d, actual %0d", want.note, first_out);
                    mismatches++;
                end
                if (second_out !== want.vel)
                begin
                    $error("second_out: expected %0d, actual %0d", want.vel, second_out);
                    mismatches++;
                end
                if (note_out_of_range !== want.oor)
                begin
                    $error("note_out_of_range: expected %0b, actual %0b",
                           want.oor, note_out_of_range);
                    mismatches++;
                end
                if (last_in_run !== want.last)
                begin
                    $error("last_in_run: expected %0b, actual %0b", want.last, last_in_run);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any transaction, result or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe || cfg_write)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic queue_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2);
        midi_msg_t m;
        m = '{status: st, d1: d1, d2: d2};
        pending_msgs.push_back(m);
        msgs_sent++;
    endtask

    // wait until every transaction is taken and every result is back
    task automatic settle(input int pad);
        do
            @(posedge clk);
        while (msgs_taken != msgs_sent || expected_notes.size() != 0);
        repeat (pad) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SCALE_ROOT: key_root  = val[3:0];
            CFG_MAJOR_MODE: major_sel = val[0];
            CFG_GAINS_LOW:  gains_lo  = val[35:0];
            CFG_GAINS_HIGH: gains_hi  = val[44:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] root,
                                 input logic [CFG_DATA_W-1:0] maj,
                                 input logic [35:0] lo, input logic [44:0] hi);
        write_reg(CFG_SCALE_ROOT, root);
        write_reg(CFG_MAJOR_MODE, maj);
        write_reg(CFG_GAINS_LOW, CFG_DATA_W'(lo));
        write_reg(CFG_GAINS_HIGH, hi);
    endtask

    // gains skewed toward the emit threshold and the saturation point
    function automatic logic [8:0] draw_gain();
        case ($urandom_range(0, 6))
            0:       return 9'd0;
            1:       return 9'd2;
            2:       return GAIN_MIN;
            3:       return GAIN_FULL;
            4:       return 9'($urandom_range(257, 511));
            5:       return 9'd511;
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    function automatic logic [44:0] draw_gain_set(input int count);
        logic [44:0] v;
        int          k;
        v = '0;
        for (k = 0; k < count; k++)
            v[9*k +: 9] = draw_gain();
        return v;
    endfunction

    // mostly note messages, largely on white keys; the rest controllers and noise
    task automatic queue_random_msg();
        int          pick;
        int          v;
        logic [7:0]  st;
        logic [6:0]  n1;
        logic [6:0]  n2;
        pick = $urandom_range(0, 99);
        n1   = 7'($urandom_range(0, 127));
        n2   = 7'($urandom_range(0, 127));
        if (pick < 75)
        begin
            st = {($urandom_range(0, 1) != 0) ? MSG_NOTE_ON : MSG_NOTE_OFF,
                  4'($urandom_range(0, 15))};
            if ($urandom_range(0, 3) != 0)
            begin
                v = 12 * int'($urandom_range(0, 10)) + WHITE_CLASS[$urandom_range(0, 6)];
                if (v > 127)
                    v -= 12;
                n1 = 7'(v);
            end
            if ($urandom_range(0, 15) == 0)
                n2 = 7'd0;
        end
        else if (pick < 85)
            st = {MSG_CONTROL, 4'($urandom_range(0, 15))};
        else
            st = 8'($urandom_range(0, 255));
        queue_msg(st, n1, n2);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int ph;
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: all gains zero, so notes vanish, forwarding still works
        queue_msg(8'h90, 7'd60, 7'd100);
        queue_msg(8'hC5, 7'd12, 7'd34);
        queue_msg(8'h12, 7'd127, 7'd0);
        queue_msg(8'hB3, 7'd7, 7'd64);
        settle(DRAIN_PAD);

        // full chord, c major
        apply_setting(45'd0, 45'd1, FULL_LO, FULL_HI);
        queue_msg(8'h90, 7'd0, 7'd127);    // lowest note, bass wraps below zero
        queue_msg(8'h9F, 7'd127, 7'd1);    // highest note, upper tones past 127
        queue_msg(8'h80, 7'd62, 7'd0);     // note-off at zero velocity still sounds
        queue_msg(8'h90, 7'd64, 7'd0);     // note-on at zero velocity is dropped
        queue_msg(8'h91, 7'd61, 7'd90);    // black key
        queue_msg(8'hB0, 7'd7, 7'd100);    // controller
        queue_msg(8'hF0, 7'd127, 7'd127);
        queue_msg(8'hFF, 7'd0, 7'd0);
        queue_msg(8'h90, 7'd64, 7'd64);
        queue_msg(8'h93, 7'd65, 7'd100);
        queue_msg(8'h95, 7'd69, 7'd100);
        queue_msg(8'h9A, 7'd71, 7'd100);
        settle(DRAIN_PAD);

        // root past b, minor, gains at threshold, below it and saturated
        apply_setting(45'd15, 45'd0, {9'd257, 9'd511, 9'd2, GAIN_MIN},
                      {9'd300, 9'd1, 9'd4, 9'd0, GAIN_FULL});
        queue_msg(8'h80, 7'd60, 7'd127);
        queue_msg(8'h81, 7'd62, 7'd1);
        queue_msg(8'h92, 7'd64, 7'd127);
        queue_msg(8'h8C, 7'd65, 7'd1);
        queue_msg(8'h9E, 7'd67, 7'd127);
        queue_msg(8'h97, 7'd69, 7'd85);
        queue_msg(8'h88, 7'd71, 7'd127);
        settle(DRAIN_PAD);

        // random phases, each with its own settings and idle behavior
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: apply_setting(45'd0, 45'd1, 36'(draw_gain_set(4)), draw_gain_set(5));
                1: apply_setting(45'd15, 45'd0, 36'({$urandom, $urandom}),
                                 45'({$urandom, $urandom}));
                2: apply_setting(45'($urandom_range(0, 15)), 45'($urandom_range(0, 1)),
                                 36'(draw_gain_set(4)), draw_gain_set(5));
                3: apply_setting(45'd11, 45'd0, 36'hF_FFFF_FFFF, 45'h1FFF_FFFF_FFFF);
                4: apply_setting(45'({$urandom, $urandom}), 45'({$urandom, $urandom}),
                                 36'({$urandom, $urandom}), 45'({$urandom, $urandom}));
                default: apply_setting(45'($urandom_range(0, 15)), 45'd1,
                                       36'(draw_gain_set(4)), draw_gain_set(5));
            endcase
            sender_idles = (ph % 2 == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                queue_random_msg();
                // hold off mid-phase until the block has drained completely
                if (ph == 2 && n == ITEMS_PER_PHASE / 2)
                    settle(0);
            end
            settle(DRAIN_PAD);
        end

        settle(END_PAD);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
